FILE: src/aacsp_pkg.sv
`timescale 1ns / 1ps

package aacsp_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  localparam logic [7:0] VERSION_CODE   = 8'd24;
  localparam logic [3:0] HEADER_SKIP    = 4'd8;
  localparam logic [7:0] WIDTH_AT_RESET = 8'd80;

  // record codes
  localparam logic [7:0] CODE_POS  = 8'd1;
  localparam logic [7:0] CODE_FORE = 8'd2;
  localparam logic [7:0] CODE_BACK = 8'd4;
  localparam logic [7:0] CODE_BOTH = 8'd6;

  // payload byte positions inside records
  localparam logic [3:0] POS_LAST_ROW   = 4'd3;
  localparam logic [3:0] POS_DONE       = 4'd7;
  localparam logic [3:0] REC_GLYPH      = 4'd0;
  localparam logic [3:0] REC_RGB_FIRST  = 4'd2;
  localparam logic [3:0] REC_RGB_LAST   = 4'd4;
  localparam logic [3:0] REC_BRGB_FIRST = 4'd6;
  localparam logic [3:0] REC_BRGB_LAST  = 4'd8;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ERROR,
    OP_BODY_CODE,
    OP_BODY_CELL,
    OP_ROW,
    OP_COL,
    OP_GLYPH,
    OP_FORE,
    OP_BACK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        draw;   // record done: draw held glyph
    logic        last;   // clear parser state after this op
    logic [7:0]  data;
  } op_t;

  function automatic logic is_code(input logic [7:0] b);
    return (b == CODE_POS) || (b == CODE_FORE) || (b == CODE_BACK) || (b == CODE_BOTH);
  endfunction

endpackage

FILE: src/aacsp_front.sv
`timescale 1ns / 1ps

module aacsp_front
  import aacsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output op_t        op
);

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_HEADER,
    PH_BODY,
    PH_RECORD,
    PH_ERROR
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] idx, idx_next;
  logic [2:0] rec, rec_next;
  logic       done;

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    rec_next   = rec;
    done       = 1'b0;
    op.kind    = OP_NOP;
    op.draw    = 1'b0;
    op.last    = last_byte;
    op.data    = data_byte;
    case (phase)
      PH_VERSION: begin
        if (data_byte == VERSION_CODE) begin
          phase_next = PH_HEADER;
          idx_next   = 4'd0;
        end else begin
          op.kind    = OP_ERROR;
          phase_next = PH_ERROR;
        end
      end
      PH_HEADER: begin
        idx_next = idx + 4'd1;
        if (idx == HEADER_SKIP - 4'd1) begin
          phase_next = PH_BODY;
          idx_next   = 4'd0;
        end
      end
      PH_BODY: begin
        if (is_code(data_byte)) begin
          op.kind    = OP_BODY_CODE;
          rec_next   = data_byte[2:0];
          idx_next   = 4'd0;
          phase_next = PH_RECORD;
        end else begin
          op.kind = OP_BODY_CELL;
        end
      end
      PH_RECORD: begin
        if ({5'd0, rec} == CODE_POS) begin
          op.kind = (idx <= POS_LAST_ROW) ? OP_ROW : OP_COL;
          done    = (idx >= POS_DONE);
        end else begin
          if (idx == REC_GLYPH) begin
            op.kind = OP_GLYPH;
          end else if (idx >= REC_RGB_FIRST && idx <= REC_RGB_LAST) begin
            op.kind = ({5'd0, rec} == CODE_BACK) ? OP_BACK : OP_FORE;
          end else if (idx >= REC_BRGB_FIRST && idx <= REC_BRGB_LAST) begin
            op.kind = OP_BACK;
          end
          done    = ({5'd0, rec} == CODE_BOTH) ? (idx >= REC_BRGB_LAST) : (idx >= REC_RGB_LAST);
          op.draw = done;
        end
        idx_next = idx + 4'd1;
        if (done) begin
          phase_next = PH_BODY;
          idx_next   = 4'd0;
        end
      end
      PH_ERROR: begin
        op.kind = OP_NOP;
      end
      default: begin
        phase_next = PH_VERSION;
      end
    endcase
    if (last_byte) begin
      phase_next = PH_VERSION;
      idx_next   = 4'd0;
      rec_next   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_VERSION;
      idx   <= 4'd0;
      rec   <= 3'd0;
    end else if (take) begin
      phase <= phase_next;
      idx   <= idx_next;
      rec   <= rec_next;
    end
  end

endmodule

FILE: src/aacsp_queue.sv
`timescale 1ns / 1ps

module aacsp_queue
  import aacsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output op_t  head
);

  op_t                       mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full      = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/aacsp_back.sv
`timescale 1ns / 1ps

module aacsp_back
  import aacsp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  input  op_t         op,
  output logic        op_take,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_row,
  output logic [15:0] cell_column,
  output logic [7:0]  glyph_code,
  output logic [23:0] fore_rgb,
  output logic [23:0] back_rgb,
  output logic        bad_header
);

  logic [7:0]            width;
  logic [COORD_BITS-1:0] row, row_next, col, col_next, row_w, col_w;
  logic [23:0]           fore, fore_next, back, back_next;
  logic [7:0]            held, held_next;
  logic [COORD_BITS+7:0] row_shift, col_shift;
  logic [COORD_BITS+15:0] row_ext, col_ext;
  logic                  emit, emit_bad;
  logic [7:0]            emit_glyph;
  logic [23:0]           emit_fore, emit_back;

  assign op_take = op_valid && (!out_valid || out_ready);

  always_comb begin
    row_next   = row;
    col_next   = col;
    fore_next  = fore;
    back_next  = back;
    held_next  = held;
    emit       = 1'b0;
    emit_bad   = 1'b0;
    emit_glyph = op.data;
    emit_fore  = fore;
    emit_back  = back;
    row_w      = row;
    col_w      = col;
    if (col == COORD_BITS'(width)) begin
      col_w = '0;
      row_w = row + 1'b1;
    end
    row_shift = {row, op.data};
    col_shift = {col, op.data};
    case (op.kind)
      OP_ERROR: begin
        emit     = 1'b1;
        emit_bad = 1'b1;
      end
      OP_BODY_CODE: begin
        row_next = row_w;
        col_next = col_w;
      end
      OP_BODY_CELL: begin
        emit     = 1'b1;
        row_next = row_w;
        col_next = col_w + 1'b1;
      end
      OP_ROW:   row_next  = row_shift[COORD_BITS-1:0];
      OP_COL:   col_next  = col_shift[COORD_BITS-1:0];
      OP_GLYPH: held_next = op.data;
      OP_FORE:  fore_next = {fore[15:0], op.data};
      OP_BACK:  back_next = {back[15:0], op.data};
      default: begin
        row_next = row;
      end
    endcase
    // end of a colour record: draw the carried glyph unless it is a code
    if (op.draw && !is_code(held)) begin
      emit       = 1'b1;
      emit_glyph = held;
      emit_fore  = fore_next;
      emit_back  = back_next;
      col_next   = col + 1'b1;
    end
    // cell position as seen when the cell is drawn
    row_ext = {16'd0, (op.kind == OP_BODY_CELL) ? row_w : row};
    col_ext = {16'd0, (op.kind == OP_BODY_CELL) ? col_w : col};
    if (op.last) begin
      row_next  = '0;
      col_next  = '0;
      fore_next = '0;
      back_next = '0;
      held_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= WIDTH_AT_RESET;
      row       <= '0;
      col       <= '0;
      fore      <= '0;
      back      <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        width <= cfg_width;
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (op_take) begin
        row  <= row_next;
        col  <= col_next;
        fore <= fore_next;
        back <= back_next;
        held <= held_next;
        if (emit) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && emit) begin
      if (emit_bad) begin
        cell_row    <= '0;
        cell_column <= '0;
        glyph_code  <= '0;
        fore_rgb    <= '0;
        back_rgb    <= '0;
      end else begin
        cell_row    <= row_ext[15:0];
        cell_column <= col_ext[15:0];
        glyph_code  <= emit_glyph;
        fore_rgb    <= emit_fore;
        back_rgb    <= emit_back;
      end
      bad_header <= emit_bad;
    end
  end

endmodule

FILE: src/ansi_art_cell_stream_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// ------    ---------  -------------------  --------------------------------------
// input     in         in_valid/in_ready    data_byte, last_byte
// output    out        out_valid/out_ready  cell_row, cell_column, glyph_code,
//                                           fore_rgb, back_rgb, bad_header
// config    in         cfg_valid/cfg_ready  line_width
//
// One byte per cycle while the queue is not full: the front decodes a byte in
// the cycle of its transfer; the back retires one queued op per cycle into the
// output register unless the output stalls. Byte to cell: queue write, then output register.
// Synchronous reset clears parser state, queue and output valid; width -> 80.
// The four-entry op queue lets the front keep taking bytes while the output
// side stalls; in_ready drops only once the queue is full. Config always ready.

module ansi_art_cell_stream_parser
  import aacsp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_row,
  output logic [15:0] cell_column,
  output logic [7:0]  glyph_code,
  output logic [23:0] fore_rgb,
  output logic [23:0] back_rgb,
  output logic        bad_header,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  line_width
);

  op_t  front_op, head_op;
  logic q_full, q_not_empty, q_pop, in_xfer;

  assign in_ready  = !q_full;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // front: version/header/record sequencing, one op per byte
  aacsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (in_xfer),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .op        (front_op)
  );

  // short op queue decoupling decode from cursor/colour update
  aacsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_op)
  );

  // back: cursor, colours, held glyph, cell output register
  aacsp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_not_empty),
    .op          (head_op),
    .op_take     (q_pop),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_width   (line_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cell_row    (cell_row),
    .cell_column (cell_column),
    .glyph_code  (glyph_code),
    .fore_rgb    (fore_rgb),
    .back_rgb    (back_rgb),
    .bad_header  (bad_header)
  );

endmodule
